// ===== hdl/stts_pkg.sv =====
// Shared types and constants for the switch trigger track selector.
`timescale 1ns / 1ps

package stts_pkg;

   localparam int unsigned SwitchWidth = 8;
   localparam int unsigned IndexWidth  = 3;
   localparam int unsigned LastWidth   = 4;
   localparam int unsigned CountWidth  = 4;

   // Marker held in the last-switch register when no switch has been played.
   localparam logic [LastWidth-1:0] NO_SWITCH = 4'd15;

   typedef enum logic [1:0] {
      MODE_ALTERNATE  = 2'd0,
      MODE_LAST_INPUT = 2'd1,
      MODE_PRIORITY   = 2'd2,
      MODE_HOLD       = 2'd3
   } stts_mode_type;

   localparam stts_mode_type MODE_RESET = MODE_ALTERNATE;

   typedef struct packed {
      logic [7:0] port_a_raw;
      logic [7:0] port_b_raw;
      logic       change_seen;
      logic       player_busy;
   } stts_req_type;

   typedef struct packed {
      logic                  play_valid;
      logic [IndexWidth-1:0] play_index;
      logic                  stop_request;
   } stts_rsp_type;

   typedef struct packed {
      logic [LastWidth-1:0] last_switch;
      logic                 pair_latch;
   } stts_state_type;

endpackage

// ===== hdl/stts_in_reg.sv =====
// Input register that holds one accepted request until it is processed.
`timescale 1ns / 1ps

module stts_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  stts_pkg::stts_req_type req_data,
   input  logic                  advance,
   output logic                  item_valid,
   output stts_pkg::stts_req_type item
);
   import stts_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   stts_req_type item_ff;
   logic         accept;

   // The register can take a new transfer when it is empty or its current item moves on.
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hdl/stts_decide.sv =====
// Combinational decision logic: switch reorder, count, scan and mode rules.
`timescale 1ns / 1ps

module stts_decide (
   input  stts_pkg::stts_mode_type  mode,
   input  stts_pkg::stts_req_type   item,
   input  stts_pkg::stts_state_type state_now,
   output stts_pkg::stts_rsp_type   rsp,
   output stts_pkg::stts_state_type state_next
);
   import stts_pkg::*;

   logic [SwitchWidth-1:0] sw;
   logic [SwitchWidth-1:0] sw_skip;
   logic [CountWidth-1:0]  count;
   logic                   any_all;
   logic [IndexWidth-1:0]  pos_all;
   logic                   any_skip;
   logic [IndexWidth-1:0]  pos_skip;
   logic                   stop_bit;
   logic [LastWidth-1:0]   last_eff;
   logic                   play;
   logic                   stop;
   logic [IndexWidth-1:0]  idx;

   // Port A is active low; its high nibble becomes the low nibble and any
   // pressed switch in the low nibble folds into bit 7.
   always_comb begin
      sw      = '0;
      sw[3:0] = ~item.port_a_raw[7:4];
      sw[7]   = |(~item.port_a_raw[3:0]);
   end

   // A last_switch value of 8 or above never matches a position.
   always_comb begin
      sw_skip = sw;
      if (!state_now.last_switch[LastWidth-1]) begin
         sw_skip[state_now.last_switch[IndexWidth-1:0]] = 1'b0;
      end
   end

   always_comb begin
      count = '0;
      for (int i = 0; i < SwitchWidth; i++) begin
         count = count + {{(CountWidth-1){1'b0}}, sw[i]};
      end
   end

   // Scan from the top so that the lowest set position wins.
   always_comb begin
      any_all  = 1'b0;
      pos_all  = '0;
      any_skip = 1'b0;
      pos_skip = '0;
      for (int i = SwitchWidth - 1; i >= 0; i--) begin
         if (sw[i]) begin
            any_all = 1'b1;
            pos_all = IndexWidth'(i);
         end
         if (sw_skip[i]) begin
            any_skip = 1'b1;
            pos_skip = IndexWidth'(i);
         end
      end
   end

   assign stop_bit = !item.port_b_raw[0];
   assign last_eff = item.player_busy ? state_now.last_switch : NO_SWITCH;

   always_comb begin
      play       = 1'b0;
      stop       = 1'b0;
      idx        = '0;
      state_next = state_now;
      unique case (mode)
         MODE_ALTERNATE: begin
            if (item.change_seen) begin
               if (stop_bit) begin
                  stop = 1'b1;
               end else if (!item.player_busy) begin
                  if (count == CountWidth'(1)) begin
                     play                   = 1'b1;
                     idx                    = pos_all;
                     state_next.last_switch = {1'b0, pos_all};
                  end else if (count == CountWidth'(2) && any_skip) begin
                     play                   = 1'b1;
                     idx                    = pos_skip;
                     state_next.last_switch = {1'b0, pos_skip};
                  end
               end
            end
         end
         MODE_LAST_INPUT: begin
            if (item.change_seen) begin
               if (stop_bit) begin
                  stop = 1'b1;
               end else if (count == CountWidth'(1)) begin
                  play                   = 1'b1;
                  idx                    = pos_all;
                  state_next.pair_latch  = 1'b0;
                  state_next.last_switch = {1'b0, pos_all};
                  stop = ({1'b0, pos_all} != state_now.last_switch);
               end else if (count == CountWidth'(2) && !state_now.pair_latch && any_skip) begin
                  play                   = 1'b1;
                  stop                   = 1'b1;
                  idx                    = pos_skip;
                  state_next.last_switch = {1'b0, pos_skip};
                  state_next.pair_latch  = 1'b1;
               end
            end
         end
         MODE_PRIORITY: begin
            if (item.change_seen) begin
               if (stop_bit) begin
                  stop = 1'b1;
               end else begin
                  // An idle player forgets the last track before the scan.
                  state_next.last_switch = last_eff;
                  if (any_all) begin
                     play = 1'b1;
                     if ({1'b0, pos_all} < last_eff) begin
                        stop                   = 1'b1;
                        idx                    = pos_all;
                        state_next.last_switch = {1'b0, pos_all};
                     end else begin
                        idx = last_eff[IndexWidth-1:0];
                     end
                  end
               end
            end
         end
         MODE_HOLD: begin
            if (item.change_seen && count == CountWidth'(1)) begin
               if (stop_bit) begin
                  stop = 1'b1;
               end else begin
                  play                   = 1'b1;
                  idx                    = pos_all;
                  state_next.last_switch = {1'b0, pos_all};
               end
            end else begin
               stop = 1'b1;
            end
         end
         default: begin
            stop = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp.play_valid   = play;
      rsp.play_index   = play ? idx : '0;
      rsp.stop_request = stop;
   end

endmodule

// ===== hdl/switch_trigger_track_selector_core.sv =====
// Top level of the switch trigger track selector.
`timescale 1ns / 1ps

// Usage:
// Each request transfer on req_ carries one sample of the two active-low
// switch port bytes, the change flag and the player's busy flag. Every
// request gives exactly one response on rsp_: a play request with a track
// index, a stop request, both or neither.
// A request is registered in the input register when it is accepted, decided
// combinationally from that register, and its response is then registered
// in the response register. One request per cycle is sustained while
// rsp_stall is low; the track history is updated on the same edge that loads
// the response, which lets the next sample use it at once.
// When rsp_stall is high the response register holds its transfer and the
// input register keeps the following sample; req_stall rises only when both
// are full. csr_write_enable loads trigger_mode; write it only while the
// block is idle; the block does not enforce this. Reset clears both valid
// flags, sets trigger_mode to alternating and marks track history empty.

module switch_trigger_track_selector_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  stts_pkg::stts_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output stts_pkg::stts_rsp_type rsp_data,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_write_data
);
   import stts_pkg::*;

   stts_mode_type  mode_ff;
   stts_state_type state_ff;
   stts_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   stts_rsp_type   rsp_ff;
   stts_rsp_type   rsp_in;
   logic           item_valid;
   stts_req_type   item;
   logic           advance;

   assign advance = item_valid && (!rsp_valid_ff || !rsp_stall);

   stts_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   stts_decide u_decide (
      .mode       (mode_ff),
      .item       (item),
      .state_now  (state_ff),
      .rsp        (rsp_in),
      .state_next (state_in)
   );

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff              <= MODE_RESET;
         state_ff.last_switch <= NO_SWITCH;
         state_ff.pair_latch  <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= stts_mode_type'(csr_write_data);
         end
         if (advance) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== bench/switch_trigger_track_selector_core_tb.sv =====
// Self-checking testbench for the switch trigger track selector core.
`timescale 1ns / 1ps

module switch_trigger_track_selector_core_tb;

   import stts_pkg::*;

   class track_decision_board;
      stts_mode_type        mode;
      logic [LastWidth-1:0] last_track;
      logic                 pair_taken;
      stts_rsp_type         expected_decisions[$];
      int                   errors;

      function new();
         mode       = MODE_RESET;
         last_track = NO_SWITCH;
         pair_taken = 1'b0;
         errors     = 0;
      endfunction

      function int pending();
         return expected_decisions.size();
      endfunction

      // Lowest pressed position other than skip; 8 when there is none.
      function int lowest_pressed(logic [SwitchWidth-1:0] sw, int skip);
         for (int i = 0; i < SwitchWidth; i++) begin
            if (sw[i] && i != skip) begin
               return i;
            end
         end
         return SwitchWidth;
      endfunction

      function void note_sample(stts_req_type s);
         logic [7:0]             inv;
         logic [SwitchWidth-1:0] sw;
         logic                   stop_bit;
         int                     n;
         int                     p;
         stts_rsp_type           d;
         inv = ~s.port_a_raw;
         // The high nibble moves to the low nibble; the low nibble folds into bit 7.
         sw = {4'b0000, inv[7:4]};
         if (inv[3:0] != 4'b0000) begin
            sw[7] = 1'b1;
         end
         n = $countones(sw);
         stop_bit = ~s.port_b_raw[0];
         d = '0;
         case (mode)
            MODE_ALTERNATE: begin
               if (s.change_seen) begin
                  if (stop_bit) begin
                     d.stop_request = 1'b1;
                  end else if (!s.player_busy && (n == 1 || n == 2)) begin
                     p = (n == 1) ? lowest_pressed(sw, SwitchWidth)
                                  : lowest_pressed(sw, int'(last_track));
                     if (p < SwitchWidth) begin
                        d.play_valid = 1'b1;
                        d.play_index = p[IndexWidth-1:0];
                        last_track   = p[LastWidth-1:0];
                     end
                  end
               end
            end
            MODE_LAST_INPUT: begin
               if (s.change_seen) begin
                  if (stop_bit) begin
                     d.stop_request = 1'b1;
                  end else if (n == 1) begin
                     p = lowest_pressed(sw, SwitchWidth);
                     pair_taken   = 1'b0;
                     d.play_valid = 1'b1;
                     d.play_index = p[IndexWidth-1:0];
                     if (p != int'(last_track)) begin
                        d.stop_request = 1'b1;
                        last_track     = p[LastWidth-1:0];
                     end
                  end else if (n == 2 && !pair_taken) begin
                     p = lowest_pressed(sw, int'(last_track));
                     if (p < SwitchWidth) begin
                        d.stop_request = 1'b1;
                        d.play_valid   = 1'b1;
                        d.play_index   = p[IndexWidth-1:0];
                        last_track     = p[LastWidth-1:0];
                        pair_taken     = 1'b1;
                     end
                  end
               end
            end
            MODE_PRIORITY: begin
               if (s.change_seen) begin
                  if (stop_bit) begin
                     d.stop_request = 1'b1;
                  end else begin
                     // An idle player forgets the track it last played.
                     if (!s.player_busy) begin
                        last_track = NO_SWITCH;
                     end
                     p = lowest_pressed(sw, SwitchWidth);
                     if (p < SwitchWidth) begin
                        d.play_valid = 1'b1;
                        if (p < int'(last_track)) begin
                           d.stop_request = 1'b1;
                           d.play_index   = p[IndexWidth-1:0];
                           last_track     = p[LastWidth-1:0];
                        end else begin
                           d.play_index = last_track[IndexWidth-1:0];
                        end
                     end
                  end
               end
            end
            default: begin
               if (s.change_seen && n == 1) begin
                  if (stop_bit) begin
                     d.stop_request = 1'b1;
                  end else begin
                     p = lowest_pressed(sw, SwitchWidth);
                     d.play_valid = 1'b1;
                     d.play_index = p[IndexWidth-1:0];
                     last_track   = p[LastWidth-1:0];
                  end
               end else begin
                  d.stop_request = 1'b1;
               end
            end
         endcase
         expected_decisions.push_back(d);
      endfunction

      function void check_decision(stts_rsp_type got);
         stts_rsp_type want;
         if (expected_decisions.size() == 0) begin
            $display("%0t: response transfer with none outstanding, actual %b/%0d/%b",
                     $time, got.play_valid, got.play_index, got.stop_request);
            errors++;
            return;
         end
         want = expected_decisions.pop_front();
         if (got.play_valid !== want.play_valid) begin
            $display("%0t: play_valid expected %b actual %b",
                     $time, want.play_valid, got.play_valid);
            errors++;
         end
         if (got.play_index !== want.play_index) begin
            $display("%0t: play_index expected %0d actual %0d",
                     $time, want.play_index, got.play_index);
            errors++;
         end
         if (got.stop_request !== want.stop_request) begin
            $display("%0t: stop_request expected %b actual %b",
                     $time, want.stop_request, got.stop_request);
            errors++;
         end
      endfunction
   endclass

   localparam int PhaseCount     = 8;
   localparam int PhaseSamples   = 135;
   localparam int DirectedCount  = 6;

   // Single switch, a high and a folded pair, all pressed with stop, none
   // pressed with stop, no change flag, and the lowest pair.
   localparam stts_req_type DIRECTED [DirectedCount] = '{
      {8'hEF, 8'hFF, 1'b1, 1'b0},
      {8'h7E, 8'hFF, 1'b1, 1'b0},
      {8'h00, 8'h00, 1'b1, 1'b1},
      {8'hFF, 8'hFE, 1'b1, 1'b0},
      {8'hFE, 8'hFF, 1'b0, 1'b1},
      {8'hCF, 8'hAB, 1'b1, 1'b0}
   };

   logic         clock            = 1'b0;
   logic         reset            = 1'b1;
   logic         req_valid        = 1'b0;
   logic         req_stall;
   stts_req_type req_data         = '0;
   logic         rsp_valid;
   logic         rsp_stall        = 1'b0;
   stts_rsp_type rsp_data;
   logic         csr_write_enable = 1'b0;
   logic [1:0]   csr_write_data   = 2'b00;

   int req_gap_max = 5;
   int rsp_gap_max = 5;

   track_decision_board board;

   switch_trigger_track_selector_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic stts_req_type random_sample();
      stts_req_type r;
      logic [7:0]   inv;
      logic [4:0]   slots;
      int           pick;
      int           count;
      r.port_b_raw    = 8'($urandom);
      r.port_b_raw[0] = ($urandom_range(0, 6) != 0);
      r.change_seen   = ($urandom_range(0, 7) != 0);
      r.player_busy   = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
         r.port_a_raw = 8'($urandom);
      end else begin
         // Mostly one or two pressed positions; slot 4 stands for the folded low nibble.
         pick  = $urandom_range(0, 19);
         count = (pick < 2) ? 0 : (pick < 11) ? 1 : (pick < 18) ? 2 : $urandom_range(3, 5);
         slots = '0;
         while ($countones(slots) < count) begin
            slots[$urandom_range(0, 4)] = 1'b1;
         end
         inv = {slots[3:0], 4'b0000};
         if (slots[4]) begin
            inv[3:0] = 4'($urandom_range(1, 15));
         end
         r.port_a_raw = ~inv;
      end
      return r;
   endfunction

   task automatic send_sample(input stts_req_type s);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (req_stall);
      board.note_sample(s);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_mode(input stts_mode_type m);
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.mode = m;
   endtask

   initial begin : request_side
      stts_mode_type phase_mode;
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first directed group runs on the mode left by reset.
      for (int m = 0; m < 4; m++) begin
         if (m > 0) begin
            write_mode(stts_mode_type'(m));
         end
         for (int k = 0; k < DirectedCount; k++) begin
            send_sample(DIRECTED[k]);
         end
         drain();
      end

      for (int ph = 0; ph < PhaseCount; ph++) begin
         phase_mode = (ph < 4) ? stts_mode_type'(3 - ph) : stts_mode_type'($urandom_range(0, 3));
         write_mode(phase_mode);
         req_gap_max = (ph % 3 == 2) ? 0 : 5;
         rsp_gap_max = (ph % 3 == 2) ? 0 : 5;
         for (int i = 0; i < PhaseSamples; i++) begin
            // Hold off mid-phase until every outstanding response has come back.
            if (ph == 4 && i == 60) begin
               drain();
            end
            send_sample(random_sample());
         end
         drain();
      end

      repeat (4) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : response_side
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_gap_max);
         if (stall > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         board.check_decision(rsp_data);
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== switch_trigger_track_selector_core.f =====
hdl/stts_pkg.sv
hdl/stts_in_reg.sv
hdl/stts_decide.sv
hdl/switch_trigger_track_selector_core.sv
bench/switch_trigger_track_selector_core_tb.sv
